// ===== hdl/pct_pkg.sv =====
// Shared types, codes and constants for the pin claim table.
`default_nettype none
package pct_pkg;
    localparam int DEF_PIN_COUNT  = 32;
    localparam int DEF_SLOT_COUNT = 16;
    localparam int MAX_RESULTS    = 32;
    localparam int OWN_W          = 16;
    localparam int CFG_W          = 32;

    localparam logic [2:0] OP_CLAIM_IN  = 3'd0;
    localparam logic [2:0] OP_CLAIM_ADC = 3'd1;
    localparam logic [2:0] OP_CLAIM_OUT = 3'd2;
    localparam logic [2:0] OP_RELEASE   = 3'd3;
    localparam logic [2:0] OP_DRIVE     = 3'd4;
    localparam logic [2:0] OP_QUERY     = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_PIN   = 3'd1;
    localparam logic [2:0] ST_BAD_MODE = 3'd2;
    localparam logic [2:0] ST_RESERVED = 3'd3;
    localparam logic [2:0] ST_CAP      = 3'd4;
    localparam logic [2:0] ST_TAKEN    = 3'd5;
    localparam logic [2:0] ST_MISMATCH = 3'd6;

    localparam logic [2:0] MODE_FREE = 3'd0;
    localparam logic [2:0] MODE_IN   = 3'd1;
    localparam logic [2:0] MODE_PU   = 3'd2;
    localparam logic [2:0] MODE_PD   = 3'd3;
    localparam logic [2:0] MODE_OUT  = 3'd4;
    localparam logic [2:0] MODE_ADC  = 3'd5;

    localparam logic [2:0] ACT_NONE = 3'd0;
    localparam logic [2:0] ACT_LOW  = 3'd1;
    localparam logic [2:0] ACT_HIGH = 3'd2;
    localparam logic [2:0] ACT_HIZ  = 3'd3;
    localparam logic [2:0] ACT_PU   = 3'd4;

    localparam logic [1:0] STYLE_PP   = 2'd0;
    localparam logic [1:0] STYLE_ODPU = 2'd2;

    localparam logic [2:0] REG_RESERVED = 3'd0;
    localparam logic [2:0] REG_IN_CAP   = 3'd1;
    localparam logic [2:0] REG_PU_CAP   = 3'd2;
    localparam logic [2:0] REG_PD_CAP   = 3'd3;
    localparam logic [2:0] REG_OUT_CAP  = 3'd4;
    localparam logic [2:0] REG_ADC_CAP  = 3'd5;
    localparam logic [2:0] REG_ADC_BASE = 3'd6;

    typedef struct packed {
        logic [OWN_W-1:0] owners;
        logic [2:0]       mode;
        logic             ok;
        logic             err;
        logic [1:0]       style;
    } t_rec;

    typedef struct packed {
        logic load;
        logic claim;
        logic reply;
        logic step;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic walk_done;
    } t_sts;

    function automatic logic [2:0] level_action(input logic [1:0] style, input logic lvl);
        logic [2:0] a;
        if (style == STYLE_PP) a = lvl ? ACT_HIGH : ACT_LOW;
        else if (!lvl)         a = ACT_LOW;
        else                   a = (style == STYLE_ODPU) ? ACT_PU : ACT_HIZ;
        return a;
    endfunction

    // input-mode pin with more than one owner
    function automatic logic rec_bad(input logic [OWN_W-1:0] own, input logic [2:0] mode);
        return (own != '0) && (mode != MODE_OUT) && (mode != MODE_ADC)
            && ((own & (own - OWN_W'(1))) != '0);
    endfunction
endpackage
`default_nettype wire

// ===== hdl/pct_ctrl.sv =====
// Sequencer for the pin claim table: dispatch, claim, reply and table walk.
`default_nettype none
module pct_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [2:0]    i_opcode,
    input  pct_pkg::t_sts      i_sts,
    output pct_pkg::t_cmd      o_cmd,
    output logic               o_busy
);
    import pct_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLAIM = 3'd1;
    localparam logic [2:0] S_REPLY = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] r_state, n_state;
    logic       accept;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    case (i_opcode)
                        OP_CLAIM_IN, OP_CLAIM_ADC, OP_CLAIM_OUT: n_state = S_CLAIM;
                        OP_RELEASE, OP_DRIVE:                    n_state = S_WALK;
                        default:                                 n_state = S_REPLY;
                    endcase
                end
            end
            S_CLAIM: begin
                o_cmd.claim = 1'b1;
                n_state = S_REPLY;
            end
            S_REPLY: begin
                o_cmd.reply = 1'b1;
                n_state = S_IDLE;
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                if (i_sts.walk_done) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_busy) else $error("accepted transaction did not raise busy");
    a_walk_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && i_sts.walk_done) |=> (r_state == S_FIN))
        else $error("walk end did not reach flush");
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.fin || o_cmd.reply) |=> !o_busy) else $error("no return to idle");
endmodule
`default_nettype wire

// ===== hdl/pct_dp.sv =====
// Datapath: claim table, config registers, claim checks, walk and result register.
`default_nettype none
module pct_dp #(
    parameter int PIN_COUNT  = pct_pkg::DEF_PIN_COUNT,
    parameter int SLOT_COUNT = pct_pkg::DEF_SLOT_COUNT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  pct_pkg::t_cmd                   i_cmd,
    output pct_pkg::t_sts                   o_sts,
    input  wire logic                       i_cfg_we,
    input  wire logic [2:0]                 i_cfg_idx,
    input  wire logic [pct_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic [2:0]                 i_opcode,
    input  wire logic [5:0]                 i_pin,
    input  wire logic [3:0]                 i_slot,
    input  wire logic [2:0]                 i_req_mode,
    input  wire logic [1:0]                 i_ok_level,
    input  wire logic [1:0]                 i_err_level,
    input  wire logic [1:0]                 i_drive_style,
    input  wire logic [15:0]                i_veto_mask,
    input  wire logic [15:0]                i_managed_mask,
    output logic                            o_valid,
    output logic [2:0]                      o_status,
    output logic [5:0]                      o_action_pin,
    output logic [2:0]                      o_pin_action,
    output logic [15:0]                     o_owners,
    output logic [2:0]                      o_pin_mode,
    output logic                            o_consistent,
    output logic                            o_last
);
    import pct_pkg::*;

    localparam int PW = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;

    t_rec r_tab [PIN_COUNT];
    logic [CFG_W-1:0] r_res, r_incap, r_pucap, r_pdcap, r_outcap, r_adccap;
    logic [5:0] r_adc_base;

    logic [2:0]  r_op, r_mode_req;
    logic [5:0]  r_pin;
    logic [3:0]  r_slot;
    logic [1:0]  r_ok, r_err, r_style;
    logic [15:0] r_veto, r_managed;
    logic [2:0]  r_status, r_act;

    logic [PW-1:0] r_idx;
    logic [5:0]    r_n;
    logic          r_have;
    logic [5:0]    r_p_pin;
    logic [2:0]    r_p_act, r_p_mode;
    logic [15:0]   r_p_own;

    logic          pin_ok, slot_ok, res_bit, cap_bit;
    logic [OWN_W-1:0] sb, keep;
    logic [PW-1:0] addr;
    t_rec          rec, new_rec;
    logic          wr;
    logic [2:0]    st, act;
    logic          cons;
    logic          can, hit, emit;
    logic [OWN_W-1:0] left;
    t_rec          w_rec;
    logic          w_wr;
    logic [2:0]    w_act, w_mode;
    logic [15:0]   w_own;

    function automatic logic pbit(input logic [CFG_W-1:0] m, input logic [5:0] p);
        return p[5] ? 1'b0 : m[p[4:0]];
    endfunction

    assign pin_ok  = {1'b0, r_pin} < 7'(PIN_COUNT);
    assign slot_ok = {2'b0, r_slot} < 6'(SLOT_COUNT);
    assign sb      = slot_ok ? (OWN_W'(1) << r_slot) : '0;
    assign addr    = i_cmd.step ? r_idx : r_pin[PW-1:0];
    assign rec     = r_tab[addr];
    assign res_bit = pbit(r_res, r_pin);
    assign o_sts.walk_done = (r_idx == PW'(PIN_COUNT - 1));

    // consistency as it stands after the operation; a release walk leaves
    // every entry with the slot bit cleared, so judge entries that way
    assign keep = (r_op == OP_RELEASE) ? ~sb : '1;
    always_comb begin
        cons = 1'b1;
        for (int i = 0; i < PIN_COUNT; i++)
            if (rec_bad(r_tab[i].owners & keep, r_tab[i].mode)) cons = 1'b0;
    end

    always_comb begin
        st      = ST_OK;
        act     = ACT_NONE;
        wr      = 1'b0;
        new_rec = rec;
        cap_bit = 1'b0;
        case (r_op)
            OP_CLAIM_IN: begin
                case (r_mode_req)
                    MODE_IN: cap_bit = pbit(r_incap, r_pin);
                    MODE_PU: cap_bit = pbit(r_pucap, r_pin);
                    default: cap_bit = pbit(r_pdcap, r_pin);
                endcase
                if (!pin_ok) st = ST_NO_PIN;
                else if (r_mode_req < MODE_IN || r_mode_req > MODE_PD) st = ST_BAD_MODE;
                else if (!slot_ok) st = ST_BAD_MODE;
                else if (res_bit) st = ST_RESERVED;
                else if (!cap_bit) st = ST_CAP;
                else if (rec.owners != '0 && rec.owners != sb) st = ST_TAKEN;
                else begin
                    wr = 1'b1;
                    new_rec.owners = sb;
                    new_rec.mode   = r_mode_req;
                    new_rec.ok     = 1'b0;
                    new_rec.err    = 1'b0;
                end
            end
            OP_CLAIM_ADC: begin
                cap_bit = pbit(r_adccap, r_pin) && (r_pin >= r_adc_base);
                if (!pin_ok) st = ST_NO_PIN;
                else if (!slot_ok) st = ST_BAD_MODE;
                else if (!cap_bit) st = ST_CAP;
                else if (res_bit) st = ST_RESERVED;
                else begin
                    wr = 1'b1;
                    new_rec.owners = rec.owners | sb;
                    new_rec.mode   = MODE_ADC;
                    new_rec.ok     = 1'b0;
                    new_rec.err    = 1'b0;
                end
            end
            OP_CLAIM_OUT: begin
                cap_bit = pbit(r_outcap, r_pin);
                if (!pin_ok) st = ST_NO_PIN;
                else if (r_ok > 2'd1 || r_err > 2'd1 || r_style > 2'd2) st = ST_BAD_MODE;
                else if (!slot_ok) st = ST_BAD_MODE;
                else if (r_ok == r_err) st = ST_MISMATCH;
                else if (res_bit) st = ST_RESERVED;
                else if (!cap_bit) st = ST_CAP;
                else if (rec.owners != '0) begin
                    if (rec.mode != MODE_OUT) st = ST_TAKEN;
                    else if (rec.ok != r_ok[0] || rec.err != r_err[0] || rec.style != r_style)
                        st = ST_MISMATCH;
                    else begin
                        wr = 1'b1;
                        new_rec.owners = rec.owners | sb;
                    end
                end else begin
                    wr = 1'b1;
                    new_rec.owners = sb;
                    new_rec.mode   = MODE_OUT;
                    new_rec.ok     = r_ok[0];
                    new_rec.err    = r_err[0];
                    new_rec.style  = r_style;
                    act = level_action(r_style, r_ok[0]);
                end
            end
            default: st = ST_OK;
        endcase
    end

    // one table entry per walk cycle
    assign can  = r_n < 6'(MAX_RESULTS);
    assign left = rec.owners & ~sb;
    always_comb begin
        w_rec  = '0;
        w_wr   = 1'b0;
        emit   = 1'b0;
        hit    = 1'b0;
        w_act  = ACT_NONE;
        w_own  = '0;
        w_mode = MODE_FREE;
        if (r_op == OP_RELEASE) begin
            hit = (rec.owners & sb) != '0;
            if (can && hit) begin
                w_wr = 1'b1;
                if (left != '0) begin
                    w_rec = rec;
                    w_rec.owners = left;
                end else begin
                    emit  = (rec.mode == MODE_OUT);
                    w_act = ACT_HIZ;
                end
            end
        end else begin
            hit = (rec.owners != '0) && (rec.mode == MODE_OUT)
                && ((rec.owners & r_managed) != '0);
            emit   = can && hit;
            w_own  = rec.owners;
            w_mode = rec.mode;
            w_act  = level_action(rec.style, ((rec.owners & r_veto) != '0) ? rec.err : rec.ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIN_COUNT; i++) r_tab[i] <= '0;
            r_res      <= '0;
            r_incap    <= '1;
            r_pucap    <= '1;
            r_pdcap    <= '1;
            r_outcap   <= '1;
            r_adccap   <= '0;
            r_adc_base <= 6'd26;
            r_have     <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_RESERVED: r_res      <= i_cfg_data;
                    REG_IN_CAP:   r_incap    <= i_cfg_data;
                    REG_PU_CAP:   r_pucap    <= i_cfg_data;
                    REG_PD_CAP:   r_pdcap    <= i_cfg_data;
                    REG_OUT_CAP:  r_outcap   <= i_cfg_data;
                    REG_ADC_CAP:  r_adccap   <= i_cfg_data;
                    REG_ADC_BASE: r_adc_base <= i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) r_have <= 1'b0;
            if (i_cmd.claim && wr) r_tab[addr] <= new_rec;
            if (i_cmd.reply) o_valid <= 1'b1;
            if (i_cmd.step) begin
                if (w_wr) r_tab[addr] <= w_rec;
                if (emit) begin
                    r_have <= 1'b1;
                    if (r_have) o_valid <= 1'b1;
                end
            end
            if (i_cmd.fin) o_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= i_opcode;
            r_pin      <= i_pin;
            r_slot     <= i_slot;
            r_mode_req <= i_req_mode;
            r_ok       <= i_ok_level;
            r_err      <= i_err_level;
            r_style    <= i_drive_style;
            r_veto     <= i_veto_mask;
            r_managed  <= i_managed_mask;
            r_status   <= ST_OK;
            r_act      <= ACT_NONE;
            r_idx      <= '0;
            r_n        <= '0;
        end
        if (i_cmd.claim) begin
            r_status <= st;
            r_act    <= act;
        end
        if (i_cmd.step) begin
            r_idx <= r_idx + PW'(1);
            if (emit) begin
                r_n      <= r_n + 6'd1;
                r_p_pin  <= 6'(r_idx);
                r_p_act  <= w_act;
                r_p_own  <= w_own;
                r_p_mode <= w_mode;
            end
        end
        // result register
        o_consistent <= cons;
        o_last       <= 1'b0;
        if (i_cmd.reply) begin
            o_last       <= 1'b1;
            o_action_pin <= 6'd0;
            o_pin_action <= ACT_NONE;
            o_owners     <= '0;
            o_pin_mode   <= MODE_FREE;
            o_status     <= r_status;
            if (r_op <= OP_CLAIM_OUT || r_op == OP_QUERY) begin
                o_action_pin <= r_pin;
                o_pin_action <= r_act;
                if (pin_ok) begin
                    o_owners   <= rec.owners;
                    o_pin_mode <= rec.mode;
                end else begin
                    o_status <= ST_NO_PIN;
                end
            end
        end
        if ((i_cmd.step && emit && r_have) || i_cmd.fin) begin
            o_last       <= i_cmd.fin;
            o_status     <= ST_OK;
            o_action_pin <= r_have ? r_p_pin : 6'd0;
            o_pin_action <= r_have ? r_p_act : ACT_NONE;
            o_owners     <= r_have ? r_p_own : 16'd0;
            o_pin_mode   <= r_have ? r_p_mode : MODE_FREE;
        end
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(i_cmd)) else $error("conflicting datapath commands");
    a_walk_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_n <= 6'(MAX_RESULTS))) else $error("result count overrun");
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.reply || i_cmd.fin) |=> (o_valid && o_last)) else $error("missing final result");
endmodule
`default_nettype wire

// ===== hdl/pin_claim_table_top.sv =====
// Pin claim table top: sequencer plus datapath; a new transaction is taken once busy drops.
// Claims pass through a claim state and a reply state; query and unused opcodes go straight
// to reply. Release slot and drive outputs walk one table entry per cycle, then flush; each
// walk result is held in a pending register until the next hit or the flush. Results
// cannot be held off by the receiver.
// Synchronous active-low reset clears the table to unclaimed and loads config defaults.
`default_nettype none
module pin_claim_table_top #(
    parameter int PIN_COUNT  = pct_pkg::DEF_PIN_COUNT,
    parameter int SLOT_COUNT = pct_pkg::DEF_SLOT_COUNT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic                       i_cfg_we,
    input  wire logic [2:0]                 i_cfg_idx,
    input  wire logic [pct_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic [2:0]                 i_opcode,
    input  wire logic [5:0]                 i_pin,
    input  wire logic [3:0]                 i_slot,
    input  wire logic [2:0]                 i_req_mode,
    input  wire logic [1:0]                 i_ok_level,
    input  wire logic [1:0]                 i_err_level,
    input  wire logic [1:0]                 i_drive_style,
    input  wire logic [15:0]                i_veto_mask,
    input  wire logic [15:0]                i_managed_mask,
    output logic                            o_valid,
    output logic [2:0]                      o_status,
    output logic [5:0]                      o_action_pin,
    output logic [2:0]                      o_pin_action,
    output logic [15:0]                     o_owners,
    output logic [2:0]                      o_pin_mode,
    output logic                            o_consistent,
    output logic                            o_last
);
    import pct_pkg::*;

    t_cmd cmd;
    t_sts sts;

    pct_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    pct_dp #(.PIN_COUNT(PIN_COUNT), .SLOT_COUNT(SLOT_COUNT)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_pin          (i_pin),
        .i_slot         (i_slot),
        .i_req_mode     (i_req_mode),
        .i_ok_level     (i_ok_level),
        .i_err_level    (i_err_level),
        .i_drive_style  (i_drive_style),
        .i_veto_mask    (i_veto_mask),
        .i_managed_mask (i_managed_mask),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_action_pin   (o_action_pin),
        .o_pin_action   (o_pin_action),
        .o_owners       (o_owners),
        .o_pin_mode     (o_pin_mode),
        .o_consistent   (o_consistent),
        .o_last         (o_last)
    );
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the pin claim table: directed and random command transactions.
`timescale 1ns / 100ps
module tb_top;
    import pct_pkg::*;

    localparam int NPIN      = 32;
    localparam int NSLOT     = 16;
    localparam int CYC_LIMIT = 400000;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  action_pin;
        logic [2:0]  pin_action;
        logic [15:0] owners;
        logic [2:0]  pin_mode;
        logic        consistent;
        logic        last;
    } t_res;

    typedef struct {
        logic [15:0] owners;
        logic [2:0]  mode;
        logic        ok;
        logic        err;
        logic [1:0]  style;
    } t_pinrec;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic [2:0]  i_opcode = '0;
    logic [5:0]  i_pin = '0;
    logic [3:0]  i_slot = '0;
    logic [2:0]  i_req_mode = '0;
    logic [1:0]  i_ok_level = '0;
    logic [1:0]  i_err_level = '0;
    logic [1:0]  i_drive_style = '0;
    logic [15:0] i_veto_mask = '0;
    logic [15:0] i_managed_mask = '0;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [5:0]  o_action_pin;
    logic [2:0]  o_pin_action;
    logic [15:0] o_owners;
    logic [2:0]  o_pin_mode;
    logic        o_consistent;
    logic        o_last;

    pin_claim_table_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_opcode(i_opcode), .i_pin(i_pin), .i_slot(i_slot), .i_req_mode(i_req_mode),
        .i_ok_level(i_ok_level), .i_err_level(i_err_level),
        .i_drive_style(i_drive_style), .i_veto_mask(i_veto_mask),
        .i_managed_mask(i_managed_mask), .o_valid(o_valid), .o_status(o_status),
        .o_action_pin(o_action_pin), .o_pin_action(o_pin_action),
        .o_owners(o_owners), .o_pin_mode(o_pin_mode),
        .o_consistent(o_consistent), .o_last(o_last)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    t_pinrec     table_shadow[NPIN];
    logic [31:0] cfg_shadow[7];
    t_res        expected_results[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          idle_on = 1'b1;

    function automatic bit pbit(logic [31:0] m, logic [5:0] p);
        return (p < 32) ? m[p[4:0]] : 1'b0;
    endfunction

    function automatic logic [2:0] drive_action(logic [1:0] style, logic lvl);
        if (style == STYLE_PP) return lvl ? ACT_HIGH : ACT_LOW;
        if (!lvl) return ACT_LOW;
        return (style == STYLE_ODPU) ? ACT_PU : ACT_HIZ;
    endfunction

    function automatic logic table_is_consistent();
        logic [15:0] m;
        for (int i = 0; i < NPIN; i++) begin
            m = table_shadow[i].owners;
            if (m == 0 || table_shadow[i].mode == MODE_OUT || table_shadow[i].mode == MODE_ADC)
                continue;
            if ((m & (m - 16'd1)) != 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_res mk(logic [2:0] st, logic [5:0] p, logic [2:0] a,
                                logic [15:0] o, logic [2:0] md);
        t_res r;
        r = '{st, p, a, o, md, 1'b0, 1'b0};
        return r;
    endfunction

    task automatic predict_command(logic [2:0] op, logic [5:0] p, logic [3:0] s,
                                   logic [2:0] md, logic [1:0] okl, logic [1:0] errl,
                                   logic [1:0] sty, logic [15:0] veto, logic [15:0] man);
        t_res        batch[$];
        logic [2:0]  st;
        logic [2:0]  act;
        logic [31:0] cap;
        logic [15:0] sb;
        logic        lvl;
        logic        cons;
        st = ST_OK;
        act = ACT_NONE;
        sb = 16'd1 << s;
        if (op == OP_CLAIM_IN) begin
            cap = (md == MODE_IN) ? cfg_shadow[REG_IN_CAP] :
                  (md == MODE_PU) ? cfg_shadow[REG_PU_CAP] : cfg_shadow[REG_PD_CAP];
            if (p >= NPIN) st = ST_NO_PIN;
            else if (md < 1 || md > 3) st = ST_BAD_MODE;
            else if (pbit(cfg_shadow[REG_RESERVED], p)) st = ST_RESERVED;
            else if (!pbit(cap, p)) st = ST_CAP;
            else if (table_shadow[p].owners != 0 && table_shadow[p].owners != sb) st = ST_TAKEN;
            else begin
                table_shadow[p].owners = sb;
                table_shadow[p].mode = md;
                table_shadow[p].ok = 0;
                table_shadow[p].err = 0;
            end
        end else if (op == OP_CLAIM_ADC) begin
            if (p >= NPIN) st = ST_NO_PIN;
            else if (!pbit(cfg_shadow[REG_ADC_CAP], p) || p < cfg_shadow[REG_ADC_BASE][5:0])
                st = ST_CAP;
            else if (pbit(cfg_shadow[REG_RESERVED], p)) st = ST_RESERVED;
            else begin
                table_shadow[p].owners |= sb;
                table_shadow[p].mode = MODE_ADC;
                table_shadow[p].ok = 0;
                table_shadow[p].err = 0;
            end
        end else if (op == OP_CLAIM_OUT) begin
            if (p >= NPIN) st = ST_NO_PIN;
            else if (okl > 1 || errl > 1 || sty > 2) st = ST_BAD_MODE;
            else if (okl == errl) st = ST_MISMATCH;
            else if (pbit(cfg_shadow[REG_RESERVED], p)) st = ST_RESERVED;
            else if (!pbit(cfg_shadow[REG_OUT_CAP], p)) st = ST_CAP;
            else if (table_shadow[p].owners != 0) begin
                if (table_shadow[p].mode != MODE_OUT) st = ST_TAKEN;
                else if (table_shadow[p].ok != okl[0] || table_shadow[p].err != errl[0]
                         || table_shadow[p].style != sty) st = ST_MISMATCH;
                else table_shadow[p].owners |= sb;
            end else begin
                table_shadow[p] = '{sb, MODE_OUT, okl[0], errl[0], sty};
                act = drive_action(sty, okl[0]);
            end
        end else if (op == OP_QUERY) begin
            if (p >= NPIN) st = ST_NO_PIN;
        end
        if (op <= OP_CLAIM_OUT || op == OP_QUERY) begin
            if (p < NPIN) batch.push_back(mk(st, p, act, table_shadow[p].owners,
                                             table_shadow[p].mode));
            else batch.push_back(mk(st, p, ACT_NONE, 0, MODE_FREE));
        end else if (op == OP_RELEASE || op == OP_DRIVE) begin
            for (int i = 0; i < NPIN && batch.size() < MAX_RESULTS; i++) begin
                if (op == OP_RELEASE) begin
                    if ((table_shadow[i].owners & sb) == 0) continue;
                    table_shadow[i].owners &= ~sb;
                    if (table_shadow[i].owners != 0) continue;
                    if (table_shadow[i].mode == MODE_OUT)
                        batch.push_back(mk(ST_OK, 6'(i), ACT_HIZ, 0, MODE_FREE));
                    table_shadow[i] = '{16'd0, MODE_FREE, 1'b0, 1'b0, 2'd0};
                end else begin
                    if (table_shadow[i].owners == 0 || table_shadow[i].mode != MODE_OUT)
                        continue;
                    if ((table_shadow[i].owners & man) == 0) continue;
                    lvl = (table_shadow[i].owners & veto) ? table_shadow[i].err
                                                          : table_shadow[i].ok;
                    batch.push_back(mk(ST_OK, 6'(i), drive_action(table_shadow[i].style, lvl),
                                       table_shadow[i].owners, table_shadow[i].mode));
                end
            end
            if (batch.size() == 0) batch.push_back(mk(ST_OK, 0, ACT_NONE, 0, MODE_FREE));
        end else begin
            batch.push_back(mk(ST_OK, 0, ACT_NONE, 0, MODE_FREE));
        end
        cons = table_is_consistent();
        foreach (batch[k]) batch[k].consistent = cons;
        batch[batch.size()-1].last = 1'b1;
        foreach (batch[k]) expected_results.push_back(batch[k]);
    endtask

    task automatic report_mismatch(string what);
        $display("mismatch @%0t: %s", $time, what);
        fail_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_res got, exp_r;
        if (i_rst_n && o_valid) begin
            got = '{o_status, o_action_pin, o_pin_action, o_owners, o_pin_mode,
                    o_consistent, o_last};
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
            end else begin
                exp_r = expected_results.pop_front();
                if (got.status != exp_r.status) report_mismatch($sformatf(
                    "status %0d exp %0d", got.status, exp_r.status));
                if (got.action_pin != exp_r.action_pin) report_mismatch($sformatf(
                    "action_pin %0d exp %0d", got.action_pin, exp_r.action_pin));
                if (got.pin_action != exp_r.pin_action) report_mismatch($sformatf(
                    "pin_action %0d exp %0d", got.pin_action, exp_r.pin_action));
                if (got.owners != exp_r.owners) report_mismatch($sformatf(
                    "owners %h exp %h", got.owners, exp_r.owners));
                if (got.pin_mode != exp_r.pin_mode) report_mismatch($sformatf(
                    "pin_mode %0d exp %0d", got.pin_mode, exp_r.pin_mode));
                if (got.consistent != exp_r.consistent) report_mismatch($sformatf(
                    "consistent %0d exp %0d", got.consistent, exp_r.consistent));
                if (got.last != exp_r.last) report_mismatch($sformatf(
                    "last %0d exp %0d", got.last, exp_r.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYC_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_command(logic [2:0] op, logic [5:0] p, logic [3:0] s,
                                logic [2:0] md, logic [1:0] okl, logic [1:0] errl,
                                logic [1:0] sty, logic [15:0] veto, logic [15:0] man);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_opcode <= op; i_pin <= p; i_slot <= s; i_req_mode <= md;
        i_ok_level <= okl; i_err_level <= errl; i_drive_style <= sty;
        i_veto_mask <= veto; i_managed_mask <= man;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_command(op, p, s, md, okl, errl, sty, veto, man);
        // busy covers the cycle after acceptance, so dropping start here costs nothing
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        int waited;
        waited = 0;
        while (expected_results.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_shadow[idx] = (idx == REG_ADC_BASE) ? {26'd0, val[5:0]} : val;
    endtask

    task automatic rand_command();
        logic [2:0] op;
        logic [5:0] p;
        op = (($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                            : 3'($urandom_range(0, 5)));
        p = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 31));
        if ($urandom_range(0, 3) != 0)
            send_command(op, p, 4'($urandom_range(0, 5)), 3'($urandom_range(1, 3)),
                         2'($urandom_range(0, 1)), 2'($urandom_range(0, 1)),
                         2'($urandom_range(0, 2)), 16'($urandom), 16'($urandom));
        else
            send_command(op, p, 4'($urandom), 3'($urandom), 2'($urandom), 2'($urandom),
                         2'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic test_defaults();
        send_command(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
        send_command(OP_QUERY, 63, 15, 7, 3, 3, 3, 16'hFFFF, 16'hFFFF);
        send_command(OP_CLAIM_IN, 1, 0, MODE_IN, 0, 0, 0, 0, 0);
        send_command(OP_CLAIM_IN, 1, 0, MODE_PD, 0, 0, 0, 0, 0);
        send_command(OP_CLAIM_IN, 1, 15, MODE_PU, 0, 0, 0, 0, 0);
        send_command(OP_CLAIM_IN, 2, 3, 3'd0, 0, 0, 0, 0, 0);
        send_command(OP_CLAIM_IN, 2, 3, 3'd7, 0, 0, 0, 0, 0);
        send_command(OP_CLAIM_IN, 40, 3, MODE_IN, 0, 0, 0, 0, 0);
        send_command(OP_CLAIM_ADC, 30, 2, 0, 0, 0, 0, 0, 0);
        send_command(OP_CLAIM_OUT, 5, 1, 0, 1, 0, 0, 0, 0);
        send_command(OP_CLAIM_OUT, 5, 2, 0, 1, 0, 0, 0, 0);
        send_command(OP_CLAIM_OUT, 5, 3, 0, 1, 0, 1, 0, 0);
        send_command(OP_CLAIM_OUT, 6, 1, 0, 0, 1, 1, 0, 0);
        send_command(OP_CLAIM_OUT, 7, 1, 0, 0, 1, 2, 0, 0);
        send_command(OP_CLAIM_OUT, 8, 1, 0, 1, 1, 0, 0, 0);
        send_command(OP_CLAIM_OUT, 8, 1, 0, 2, 0, 3, 0, 0);
        send_command(OP_CLAIM_OUT, 1, 4, 0, 1, 0, 0, 0, 0);
        send_command(OP_DRIVE, 0, 0, 0, 0, 0, 0, 16'h0002, 16'hFFFF);
        send_command(OP_DRIVE, 0, 0, 0, 0, 0, 0, 16'h0000, 16'h0000);
        send_command(3'd6, 9, 9, 1, 1, 1, 1, 1, 1);
        send_command(3'd7, 9, 9, 1, 1, 1, 1, 1, 1);
        send_command(OP_RELEASE, 0, 1, 0, 0, 0, 0, 0, 0);
        send_command(OP_RELEASE, 0, 2, 0, 0, 0, 0, 0, 0);
        send_command(OP_RELEASE, 0, 9, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_config_masks();
        write_reg(REG_RESERVED, 32'h8000_0001);
        write_reg(REG_IN_CAP, 32'hFFFF_FFFE);
        write_reg(REG_PU_CAP, 32'h0000_FFFF);
        write_reg(REG_PD_CAP, 32'hFFFF_0000);
        write_reg(REG_OUT_CAP, 32'h7FFF_FFF0);
        write_reg(REG_ADC_CAP, 32'hFFFF_FFFF);
        write_reg(REG_ADC_BASE, 32'd63);
        send_command(OP_CLAIM_IN, 0, 0, MODE_IN, 0, 0, 0, 0, 0);
        send_command(OP_CLAIM_ADC, 31, 0, 0, 0, 0, 0, 0, 0);
        send_command(OP_CLAIM_OUT, 2, 0, 0, 0, 1, 0, 0, 0);
        write_reg(REG_ADC_BASE, 32'd0);
        send_command(OP_CLAIM_ADC, 31, 0, 0, 0, 0, 0, 0, 0);
        send_command(OP_CLAIM_ADC, 20, 0, 0, 0, 0, 0, 0, 0);
        send_command(OP_CLAIM_IN, 20, 0, MODE_PU, 0, 0, 0, 0, 0);
        send_command(OP_CLAIM_ADC, 20, 5, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 75; i++) rand_command();
    endtask

    task automatic test_random_defaults();
        write_reg(REG_RESERVED, 32'h0);
        write_reg(REG_IN_CAP, 32'hFFFF_FFFF);
        write_reg(REG_PU_CAP, 32'hFFFF_FFFF);
        write_reg(REG_PD_CAP, 32'hFFFF_FFFF);
        write_reg(REG_OUT_CAP, 32'hFFFF_FFFF);
        write_reg(REG_ADC_CAP, 32'hFFFF_0000);
        write_reg(REG_ADC_BASE, 32'd26);
        for (int i = 0; i < 70; i++) rand_command();
        // dense output pins so drive produces long result bursts
        for (int i = 0; i < 32; i++) send_command(OP_CLAIM_OUT, i, 0, 0, 1, 0, 0, 0, 0);
        send_command(OP_DRIVE, 0, 0, 0, 0, 0, 0, 16'h0001, 16'h0001);
        send_command(OP_DRIVE, 0, 0, 0, 0, 0, 0, 16'h0000, 16'hFFFF);
        idle_on = 1'b0;
        for (int i = 0; i < 40; i++) rand_command();
        send_command(OP_RELEASE, 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    initial begin
        int waited;
        for (int i = 0; i < NPIN; i++) table_shadow[i] = '{16'd0, MODE_FREE, 1'b0, 1'b0, 2'd0};
        cfg_shadow[REG_RESERVED] = 0;
        cfg_shadow[REG_IN_CAP] = '1;
        cfg_shadow[REG_PU_CAP] = '1;
        cfg_shadow[REG_PD_CAP] = '1;
        cfg_shadow[REG_OUT_CAP] = '1;
        cfg_shadow[REG_ADC_CAP] = 0;
        cfg_shadow[REG_ADC_BASE] = 26;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_config_masks();
        test_random_defaults();
        waited = 0;
        while (expected_results.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
